/* rtl/bfcc_pkg.sv */
// ----------------------------------------------------------------------------
// Coulomb counter package
// Operation codes, fixed field widths and decode constants shared by the
// channel interfaces, the serial divider and the top level.
// ----------------------------------------------------------------------------
package bfcc_pkg;

  typedef enum logic [1:0] {
    OP_FRAME     = 2'd0,
    OP_TICK      = 2'd1,
    OP_SET_CAP   = 2'd2,
    OP_RESET_CAP = 2'd3
  } op_e;

  localparam int BYTE_W      = 8;
  localparam int CAP_IN_W    = 32;
  localparam int SAVED_W     = 33;
  localparam int CURRENT_W   = 16;
  localparam int VOLT_RAW_W  = 14;
  localparam int VOLTAGE_W   = 18;

  localparam int SECONDS_IN_HOUR = 3600;
  localparam int SECONDS_W       = 12;
  localparam int VOLT_OFFSET     = 60013;

  // Divider handshake with the sequencer.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* rtl/bfcc_if.sv */
// ----------------------------------------------------------------------------
// Coulomb counter channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bfcc_in_if;
  import bfcc_pkg::*;

  logic                  valid;
  logic                  ready;
  op_e                   operation;
  logic                  frame_ok;
  logic [BYTE_W-1:0]     current_low_byte;
  logic [BYTE_W-1:0]     current_high_byte;
  logic [BYTE_W-1:0]     voltage_low_byte;
  logic [BYTE_W-1:0]     voltage_high_byte;
  logic [CAP_IN_W-1:0]   capacity_value;

  modport source (
    output valid, operation, frame_ok, current_low_byte, current_high_byte,
           voltage_low_byte, voltage_high_byte, capacity_value,
    input  ready
  );

  modport sink (
    input  valid, operation, frame_ok, current_low_byte, current_high_byte,
           voltage_low_byte, voltage_high_byte, capacity_value,
    output ready
  );
endinterface

interface bfcc_out_if;
  import bfcc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        frame_accepted;
  logic signed [CURRENT_W-1:0] current_ma;
  logic [VOLTAGE_W-1:0]        voltage_tenth_mv;
  logic [CAP_IN_W-1:0]         capacity_mah;

  modport source (
    output valid, frame_accepted, current_ma, voltage_tenth_mv, capacity_mah,
    input  ready
  );

  modport sink (
    input  valid, frame_accepted, current_ma, voltage_tenth_mv, capacity_mah,
    output ready
  );
endinterface

/* rtl/bfcc_divider.sv */
// ----------------------------------------------------------------------------
// Coulomb counter serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfcc_divider #(
  parameter int DVD_W = 40,
  parameter int DIV_W = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bfcc_pkg::div_ctl_t       ctl_i,
  output bfcc_pkg::div_sts_t       sts_o,
  input  logic [DVD_W-1:0]         dividend_i,
  input  logic [DIV_W-1:0]         divisor_i,
  output logic [DVD_W-1:0]         quotient_o
);
  import bfcc_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  dsr_q, dsr_d;

  logic [DIV_W:0]    partial;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign partial = {rem_q, quo_q[DVD_W-1]};
  assign trial   = partial - {1'b0, dsr_q};
  assign fits    = (partial >= {1'b0, dsr_q});

  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (ctl_i.start) begin
      step_d = STEP_W'(DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (step_q != '0) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d  = fits ? trial[DIV_W-1:0] : partial[DIV_W-1:0];
      quo_d  = {quo_q[DVD_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      done_d = (step_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign sts_o.busy = (step_q != '0);
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/battery_frame_coulomb_counter.sv */
// ----------------------------------------------------------------------------
// Battery frame coulomb counter
// Decodes battery sensor frames and integrates current into a capacity.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item per handshake: a frame (four raw bytes plus a
//   checksum flag), a one-second tick, a set-capacity value or a request to
//   restore the saved capacity. out_o returns exactly one result item per
//   input item: frame flag, latest current, latest voltage, capacity in mAh.
//   cfg_we_i/cfg_wdata_i write the saved capacity (negative means none).
//   Sequence: a frame, set, restore or empty-tick item goes from idle to
//   the emit state, which loads the output register once the slot is
//   free. A tick with samples registers the divisor (prep), starts the
//   serial restoring divider (start; one quotient bit per cycle), waits
//   for it to finish and then emits. in_i.ready is high only while the
//   sequencer is idle, so the next item is taken only after the result is
//   registered; the block takes no new item while one is in flight.
//   A finished result sits in the output register until taken; the block
//   still accepts the next item, then holds it until the slot frees.
//   Reset clears all counting state, capacity and output valid, and sets
//   the saved capacity to "none saved".
// ----------------------------------------------------------------------------
module battery_frame_coulomb_counter #(
  parameter int SAMPLE_COUNT_MAX       = 255,
  parameter int CAPACITY_FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bfcc_in_if.sink                      in_i,
  bfcc_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [bfcc_pkg::SAVED_W-1:0] cfg_wdata_i
);
  import bfcc_pkg::*;

  localparam int F     = CAPACITY_FRACTION_BITS;
  localparam int CNT_W = $clog2(SAMPLE_COUNT_MAX + 1);
  // |sum| stays below 32768 * 2^CNT_W
  localparam int SUM_W = CURRENT_W + CNT_W;
  localparam int CAP_W = SAVED_W + F;
  localparam int DVD_W = SUM_W + F;
  localparam int DIV_W = CNT_W + SECONDS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [SAVED_W-1:0]          saved_q;
  logic signed [CURRENT_W-1:0] cur_q, cur_d;
  logic [VOLTAGE_W-1:0]        volt_q, volt_d;
  logic signed [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic signed [CAP_W-1:0]     cap_q, cap_d;
  logic                        acc_q, acc_d;
  logic [DIV_W-1:0]            dsr_q, dsr_d;

  logic                        out_valid_q;
  logic                        out_acc_q;
  logic signed [CURRENT_W-1:0] out_cur_q;
  logic [VOLTAGE_W-1:0]        out_volt_q;
  logic [CAP_IN_W-1:0]         out_cap_q;
  logic                        emit;

  logic signed [CURRENT_W-1:0] frame_cur;
  logic [VOLT_RAW_W-1:0]       volt_raw;
  logic [VOLTAGE_W-1:0]        frame_volt;

  logic                        neg;
  logic [SUM_W-1:0]            mag;
  logic [DVD_W-1:0]            quotient;
  div_ctl_t                    div_ctl;
  div_sts_t                    div_sts;

  logic signed [CAP_W:0]       cap_ext;
  logic signed [CAP_W:0]       q_ext;
  logic signed [CAP_W:0]       cap_sum;
  logic signed [CAP_W-1:0]     cap_sat;

  // Offset-binary current: flip the top bit.
  assign frame_cur = {~in_i.current_high_byte[BYTE_W-1],
                      in_i.current_high_byte[BYTE_W-2:0], in_i.current_low_byte};

  // Voltage: raw * 10 + offset, the multiply as two shifts.
  assign volt_raw   = {in_i.voltage_high_byte[VOLT_RAW_W-BYTE_W-1:0],
                       in_i.voltage_low_byte};
  assign frame_volt = {1'b0, volt_raw, 3'b000} + {3'b000, volt_raw, 1'b0}
                    + VOLTAGE_W'(VOLT_OFFSET);

  // Magnitude of the charge sum, shifted up to fixed point for the divider.
  assign neg = sum_q[SUM_W-1];
  assign mag = neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  bfcc_divider #(
    .DVD_W (DVD_W),
    .DIV_W (DIV_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .sts_o      (div_sts),
    .dividend_i ({mag, {F{1'b0}}}),
    .divisor_i  (dsr_q),
    .quotient_o (quotient)
  );

  // Add or subtract the increment, saturate at the signed capacity limits.
  assign cap_ext = {cap_q[CAP_W-1], cap_q};
  assign q_ext   = {1'b0, CAP_W'(quotient)};
  assign cap_sum = neg ? (cap_ext - q_ext) : (cap_ext + q_ext);
  always_comb begin
    if (cap_sum[CAP_W] != cap_sum[CAP_W-1]) begin
      cap_sat = cap_sum[CAP_W] ? {1'b1, {(CAP_W-1){1'b0}}} : {1'b0, {(CAP_W-1){1'b1}}};
    end else begin
      cap_sat = cap_sum[CAP_W-1:0];
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign emit          = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
  assign div_ctl.start = (state_q == S_START);

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    volt_d  = volt_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    cap_d   = cap_q;
    acc_d   = acc_q;
    dsr_d   = dsr_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          acc_d   = 1'b0;
          state_d = S_EMIT;
          unique case (in_i.operation)
            OP_FRAME: begin
              if (in_i.frame_ok) begin
                acc_d  = 1'b1;
                cur_d  = frame_cur;
                volt_d = frame_volt;
                // drop the sample from the sum once the count is full
                if (cnt_q < CNT_W'(SAMPLE_COUNT_MAX)) begin
                  sum_d = sum_q + SUM_W'(frame_cur);
                  cnt_d = cnt_q + CNT_W'(1);
                end
              end
            end
            OP_TICK: begin
              if (cnt_q != '0) begin
                state_d = S_PREP;
              end
            end
            OP_SET_CAP: begin
              cap_d = {1'b0, in_i.capacity_value, {F{1'b0}}};
            end
            OP_RESET_CAP: begin
              if (!saved_q[SAVED_W-1]) begin
                cap_d = {1'b0, saved_q[SAVED_W-2:0], {F{1'b0}}};
              end
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        // samples * seconds per hour, registered before the divider loads it
        dsr_d   = DIV_W'(cnt_q) * DIV_W'(SECONDS_IN_HOUR);
        state_d = S_START;
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_sts.done) begin
          cap_d   = cap_sat;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      saved_q     <= '1;
      cur_q       <= '0;
      volt_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      cap_q       <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      volt_q  <= volt_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
      acc_q   <= acc_d;
      if (cfg_we_i) begin
        saved_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload and divisor hold no reset.
  always_ff @(posedge clk_i) begin
    dsr_q <= dsr_d;
    if (emit) begin
      out_acc_q  <= acc_q;
      out_cur_q  <= cur_q;
      out_volt_q <= volt_q;
      // clamp a negative capacity at zero, else drop the fraction
      out_cap_q  <= cap_q[CAP_W-1] ? '0 : cap_q[F+CAP_IN_W-1:F];
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.frame_accepted   = out_acc_q;
  assign out_o.current_ma       = out_cur_q;
  assign out_o.voltage_tenth_mv = out_volt_q;
  assign out_o.capacity_mah     = out_cap_q;

`ifndef SYNTH
  // sample count never passes its limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SAMPLE_COUNT_MAX))
    else $error("sample count above limit");

  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == S_WAIT))
    else $error("divider done outside wait state");

  // divider runs only while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.busy |-> (state_q == S_WAIT))
    else $error("divider busy outside wait state");

  // a completed tick clears the second's sum and count
  a_tick_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && div_sts.done) |=> (cnt_q == '0 && sum_q == '0))
    else $error("tick left charge sum or count");

  // a result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !emit)
    else $error("result overwritten while stalled");
`endif

endmodule
